@@ sv/filename_char_sanitizer_defines.svh @@
// ============================================================================
// filename_char_sanitizer_defines.svh
// Assertion macros shared by the file name sanitizer. Each macro samples on
// the rising edge of clock and is disabled while reset is high.
// ============================================================================
`ifndef FILENAME_CHAR_SANITIZER_DEFINES_SVH
`define FILENAME_CHAR_SANITIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/fcs_pkg.sv @@
// ============================================================================
// fcs_pkg
// Types, register indexes and character codes of the file name sanitizer.
// ============================================================================
package fcs_pkg;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_POLICY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_POLICY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_BYTE = 2'd2;

   // Character policies. Code 3 behaves like the spaces-only policy.
   localparam logic [1:0] CHAR_POLICY_ASCII  = 2'd0;
   localparam logic [1:0] CHAR_POLICY_SYMBOL = 2'd1;
   localparam logic [1:0] CHAR_POLICY_SPACES = 2'd2;

   // Space policies. Code 3 behaves like keep.
   localparam logic [1:0] SPACE_POLICY_SUBST  = 2'd0;
   localparam logic [1:0] SPACE_POLICY_REMOVE = 2'd1;
   localparam logic [1:0] SPACE_POLICY_KEEP   = 2'd2;

   localparam logic [7:0] SEPARATOR_RESET = 8'h2F;

   // Held space counter saturates at the smaller of the limit and 255.
   localparam int MAX_HELD_SPACES = 255;
   localparam logic [7:0] HELD_LIMIT =
      (MAX_HELD_SPACES > 255) ? 8'd255 : 8'(MAX_HELD_SPACES);

   // ASCII characters that the policies look at or produce.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDERLINE = 8'h5F;
   localparam logic [7:0] CH_BAR       = 8'h7C;
   localparam logic [7:0] CH_DEL       = 8'h7F;

   // UTF-8 look-alike symbols: lead byte, middle bytes and final bytes.
   localparam logic [7:0] U8_LEAD       = 8'hE2;
   localparam logic [7:0] U8_MID_CTRL   = 8'h90;
   localparam logic [7:0] U8_MID_MATH   = 8'h88;
   localparam logic [7:0] U8_MID_PUNCT  = 8'h80;
   localparam logic [7:0] U8_MID_ORDER  = 8'h89;
   localparam logic [7:0] U8_CTRL_BASE  = 8'h80;
   localparam logic [7:0] U8_SPACE_SYM  = 8'hA0;
   localparam logic [7:0] U8_DEL_SYM    = 8'hA1;
   localparam logic [7:0] U8_BSLASH_SYM = 8'h96;
   localparam logic [7:0] U8_SLASH_SYM  = 8'h95;
   localparam logic [7:0] U8_COLON_SYM  = 8'hB6;
   localparam logic [7:0] U8_BAR_SYM    = 8'hA3;
   localparam logic [7:0] U8_STAR_SYM   = 8'h97;
   localparam logic [7:0] U8_QUEST_SYM  = 8'hBD;
   localparam logic [7:0] U8_QUOTE_SYM  = 8'h9D;
   localparam logic [7:0] U8_LESS_SYM   = 8'hBA;
   localparam logic [7:0] U8_GREAT_SYM  = 8'hBB;

   // Mapping of one byte: up to three output bytes and a hold request.
   typedef struct packed {
      logic [1:0] byte_count;
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic [7:0] out_third;
      logic       hold;
   } map_result_type;

   // Control of the held space counter for one advancing word.
   typedef struct packed {
      logic advance;
      logic emit;
      logic hold;
      logic eon;
   } hold_ctrl_type;

   function automatic map_result_type put1(input logic [7:0] a);
      map_result_type r;
      r            = '0;
      r.byte_count = 2'd1;
      r.out_first  = a;
      return r;
   endfunction

   function automatic map_result_type put3(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
      map_result_type r;
      r            = '0;
      r.byte_count = 2'd3;
      r.out_first  = a;
      r.out_second = b;
      r.out_third  = c;
      return r;
   endfunction

   // Space-like byte under the space policy: substitute, drop or hold.
   function automatic map_result_type space_map(input logic [1:0] space_policy,
                                                input map_result_type subst);
      map_result_type r;
      r = '0;
      priority if (space_policy == SPACE_POLICY_SUBST) begin
         r = subst;
      end else if (space_policy == SPACE_POLICY_REMOVE) begin
         r = '0;
      end else begin
         r.hold = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ sv/fcs_if.sv @@
// ============================================================================
// fcs_if
// Valid/ready channels of the file name sanitizer: name bytes in, results out.
// ============================================================================
interface fcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_name;

   modport source (output valid, output in_byte, output end_of_name, input ready);
   modport sink   (input valid, input in_byte, input end_of_name, output ready);
endinterface

interface fcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] released_spaces;
   logic [1:0] byte_count;
   logic [7:0] out_first;
   logic [7:0] out_second;
   logic [7:0] out_third;
   logic       name_done;

   modport source (output valid, output released_spaces, output byte_count,
                   output out_first, output out_second, output out_third,
                   output name_done, input ready);
   modport sink   (input valid, input released_spaces, input byte_count,
                   input out_first, input out_second, input out_third,
                   input name_done, output ready);
endinterface

@@ sv/fcs_char_map.sv @@
// ============================================================================
// fcs_char_map
// Maps one name byte to zero to three output bytes or a held space.
// ============================================================================
module fcs_char_map
   import fcs_pkg::*;
(
   input  logic [7:0]     in_byte,
   input  logic [1:0]     char_policy,
   input  logic [1:0]     space_policy,
   input  logic [7:0]     separator_byte,
   output map_result_type result
);

   always_comb begin
      result = '0;
      priority if (in_byte == CH_NUL) begin
         result = put1(CH_NUL);
      end else if (char_policy == CHAR_POLICY_SYMBOL) begin
         priority if (in_byte < CH_SPACE) begin
            result = put3(U8_LEAD, U8_MID_CTRL, U8_CTRL_BASE + in_byte);
         end else if (in_byte == CH_DEL) begin
            result = put3(U8_LEAD, U8_MID_CTRL, U8_DEL_SYM);
         end else if (in_byte == CH_SPACE) begin
            result = space_map(space_policy, put3(U8_LEAD, U8_MID_CTRL, U8_SPACE_SYM));
         end else if (in_byte == CH_BACKSLASH) begin
            result = put3(U8_LEAD, U8_MID_MATH, U8_BSLASH_SYM);
         end else if (in_byte == CH_SLASH) begin
            result = put3(U8_LEAD, U8_MID_MATH, U8_SLASH_SYM);
         end else if (in_byte == CH_COLON) begin
            result = put3(U8_LEAD, U8_MID_MATH, U8_COLON_SYM);
         end else if (in_byte == CH_BAR) begin
            result = put3(U8_LEAD, U8_MID_MATH, U8_BAR_SYM);
         end else if (in_byte == CH_STAR) begin
            result = put3(U8_LEAD, U8_MID_MATH, U8_STAR_SYM);
         end else if (in_byte == CH_QUESTION) begin
            result = put3(U8_LEAD, U8_MID_PUNCT, U8_QUEST_SYM);
         end else if (in_byte == CH_QUOTE) begin
            result = put3(U8_LEAD, U8_MID_PUNCT, U8_QUOTE_SYM);
         end else if (in_byte == CH_LESS) begin
            result = put3(U8_LEAD, U8_MID_ORDER, U8_LESS_SYM);
         end else if (in_byte == CH_GREATER) begin
            result = put3(U8_LEAD, U8_MID_ORDER, U8_GREAT_SYM);
         end else begin
            result = put1(in_byte);
         end
      end else if (char_policy == CHAR_POLICY_ASCII) begin
         priority if (in_byte == CH_CR) begin
            result = '0;
         end else if (in_byte <= CH_SPACE || in_byte == CH_DEL) begin
            result = space_map(space_policy, put1(CH_UNDERLINE));
         end else if (in_byte == CH_SLASH || in_byte == CH_COLON || in_byte == CH_BAR) begin
            result = put1(CH_DASH);
         end else if (in_byte == CH_STAR) begin
            result = put1(CH_PLUS);
         end else if (in_byte == CH_QUESTION) begin
            result = put1(CH_UNDERLINE);
         end else if (in_byte == CH_QUOTE) begin
            result = put1(CH_APOS);
         end else if (in_byte == CH_LESS) begin
            result = put1(CH_LPAREN);
         end else if (in_byte == CH_GREATER) begin
            result = put1(CH_RPAREN);
         end else if (in_byte == separator_byte) begin
            result = put1(CH_DASH);
         end else begin
            result = put1(in_byte);
         end
      end else begin
         // Spaces-only policy; the unused code 3 lands here as well.
         priority if (in_byte == CH_SPACE) begin
            result = space_map(space_policy, put1(CH_UNDERLINE));
         end else if (in_byte == CH_SLASH || in_byte == separator_byte) begin
            result = put1(CH_DASH);
         end else begin
            result = put1(in_byte);
         end
      end
   end

endmodule

@@ sv/fcs_space_hold.sv @@
// ============================================================================
// fcs_space_hold
// Saturating count of held spaces, released before the next written byte.
// ============================================================================
module fcs_space_hold
   import fcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  hold_ctrl_type ctrl,
   output logic [7:0]    released,
   output logic [7:0]    held_count
);

   logic [7:0] held_ff;
   logic [7:0] held_in;
   logic [7:0] after_emit;

   assign released   = ctrl.emit ? held_ff : 8'd0;
   assign held_count = held_ff;

   always_comb begin
      after_emit = ctrl.emit ? 8'd0 : held_ff;
      held_in    = held_ff;
      if (ctrl.advance) begin
         held_in = after_emit;
         if (ctrl.hold && after_emit < HELD_LIMIT) begin
            held_in = after_emit + 8'd1;
         end
         // Spaces still held when the name ends are dropped.
         if (ctrl.eon) begin
            held_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'd0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

@@ sv/filename_char_sanitizer.sv @@
// ============================================================================
// filename_char_sanitizer
// Streams a file name byte by byte and rewrites it into a file system safe
// form, holding kept spaces as a count that is released before the next byte.
// ============================================================================
//
//   Channel  Role     Handshake      Payload
//   req_ch   input    valid/ready    in_byte, end_of_name
//   rsp_ch   output   valid/ready    released_spaces, byte_count, out_first,
//                                    out_second, out_third, name_done
//   csr_*    config   write enable   csr_index, csr_wdata (no read-back)
//
// The block takes one word per cycle while its results are taken and gives one
// result per word; each word passes an input register, then the byte mapping
// and the held space counter, then the result register.
// Reset is synchronous and active high. It empties both registers, clears the
// held space count and loads the register defaults (ASCII substitutes,
// spaces to underscore, separator '/').
// A stalled result holds the result register; the input register still drains
// into it in the cycle the result is taken, so a full pipe keeps its rate.
// The input side stalls only while both registers are full and the result
// waits.
//
module filename_char_sanitizer
   import fcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fcs_req_if.sink                req_ch,
   fcs_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "filename_char_sanitizer_defines.svh"

   // Configuration registers.
   logic [1:0] char_policy_ff,  char_policy_in;
   logic [1:0] space_policy_ff, space_policy_in;
   logic [7:0] separator_ff,    separator_in;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff,  s1_byte_in;
   logic       s1_eon_ff,   s1_eon_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_released_ff, rsp_released_in;
   logic [1:0] rsp_count_ff,    rsp_count_in;
   logic [7:0] rsp_first_ff,    rsp_first_in;
   logic [7:0] rsp_second_ff,   rsp_second_in;
   logic [7:0] rsp_third_ff,    rsp_third_in;
   logic       rsp_done_ff,     rsp_done_in;

   logic           req_take;
   logic           s1_advance;
   map_result_type map_result;
   hold_ctrl_type  hold_ctrl;
   logic [7:0]     released;
   logic [7:0]     held_count;

   // The input register moves on when the result register is free or is
   // being emptied this cycle; it can take a new word when it is empty or moves on.
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Configuration writes; an index beyond the list is ignored.
   always_comb begin
      char_policy_in  = char_policy_ff;
      space_policy_in = space_policy_ff;
      separator_in    = separator_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHAR_POLICY:    char_policy_in  = csr_wdata[1:0];
            CSR_SPACE_POLICY:   space_policy_in = csr_wdata[1:0];
            CSR_SEPARATOR_BYTE: separator_in    = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_eon_in   = s1_eon_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_ch.in_byte;
         s1_eon_in   = req_ch.end_of_name;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   fcs_char_map u_char_map (
      .in_byte        (s1_byte_ff),
      .char_policy    (char_policy_ff),
      .space_policy   (space_policy_ff),
      .separator_byte (separator_ff),
      .result         (map_result)
   );

   // Any written byte releases the held spaces ahead of it.
   assign hold_ctrl.advance = s1_advance;
   assign hold_ctrl.emit    = (map_result.byte_count != 2'd0);
   assign hold_ctrl.hold    = map_result.hold;
   assign hold_ctrl.eon     = s1_eon_ff;

   fcs_space_hold u_space_hold (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (hold_ctrl),
      .released   (released),
      .held_count (held_count)
   );

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_released_in = rsp_released_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_third_in    = rsp_third_ff;
      rsp_done_in     = rsp_done_ff;
      if (s1_advance) begin
         rsp_valid_in    = 1'b1;
         rsp_released_in = released;
         rsp_count_in    = map_result.byte_count;
         rsp_first_in    = map_result.out_first;
         rsp_second_in   = map_result.out_second;
         rsp_third_in    = map_result.out_third;
         rsp_done_in     = s1_eon_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_policy_ff  <= CHAR_POLICY_ASCII;
         space_policy_ff <= SPACE_POLICY_SUBST;
         separator_ff    <= SEPARATOR_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         char_policy_ff  <= char_policy_in;
         space_policy_ff <= space_policy_in;
         separator_ff    <= separator_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_byte_ff      <= s1_byte_in;
      s1_eon_ff       <= s1_eon_in;
      rsp_released_ff <= rsp_released_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_second_ff   <= rsp_second_in;
      rsp_third_ff    <= rsp_third_in;
      rsp_done_ff     <= rsp_done_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.released_spaces = rsp_released_ff;
   assign rsp_ch.byte_count      = rsp_count_ff;
   assign rsp_ch.out_first       = rsp_first_ff;
   assign rsp_ch.out_second      = rsp_second_ff;
   assign rsp_ch.out_third       = rsp_third_ff;
   assign rsp_ch.name_done       = rsp_done_ff;

   // Written bytes and the end of a name both leave no held spaces behind.
   `FCS_ASSERT_NEXT(a_held_cleared, s1_advance && (hold_ctrl.emit || s1_eon_ff),
                    held_count == 8'd0, "held spaces survived a written byte or a name end")
   // A result without bytes never releases spaces.
   `FCS_ASSERT_SAME(a_no_release_empty, rsp_valid_ff && rsp_count_ff == 2'd0,
                    rsp_released_ff == 8'd0, "spaces released by a result without bytes")
   // The held count never passes its saturation limit.
   `FCS_ASSERT_SAME(a_held_limit, 1'b1, held_count <= HELD_LIMIT,
                    "held space count above its limit")

endmodule
